// ----- rtl/xmltok_pkg.sv -----
`timescale 1ns / 1ps

package xmltok_pkg;

   // Markup event codes carried by each result.
   typedef enum logic [2:0] {
      EV_NONE          = 3'd0,
      EV_TAG_OPEN      = 3'd1,
      EV_TAG_CLOSE     = 3'd2,
      EV_NAME_END      = 3'd3,
      EV_ATTR_NAME_END = 3'd4,
      EV_VALUE_END     = 3'd5
   } xmltok_event_type;

   // Error codes carried by each result.
   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_OPEN_IN_TAG   = 2'd1,
      ERR_CLOSE_OUT_TAG = 2'd2
   } xmltok_error_type;

   // Bytes with a meaning in markup.
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // Register port geometry and register indexes.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [0:0]  REG_ACCEPT_SQ  = 1'b0;

   // Parse flags kept between bytes.
   typedef struct packed {
      logic in_tag;
      logic in_tag_name;
      logic in_quoted_value;
      logic in_attribute_name;
      logic end_tag_seen;
      logic token_open;
   } xmltok_flags_type;

endpackage

// ----- rtl/xmltok_if.sv -----
`timescale 1ns / 1ps

interface xmltok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface xmltok_rsp_if
   import xmltok_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   xmltok_event_type        event_res;
   xmltok_error_type        error;
   logic [LENGTH_WIDTH-1:0] token_length;
   logic                    closing_tag;
   logic [7:0]              stored_byte;

   modport source (output valid, output event_res, output error, output token_length,
                   output closing_tag, output stored_byte, input ready);
   modport sink (input valid, input event_res, input error, input token_length,
                 input closing_tag, input stored_byte, output ready);
endinterface

// ----- rtl/xmltok_csr.sv -----
`timescale 1ns / 1ps

module xmltok_csr
   import xmltok_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic                      accept_single_quote
);

   logic       asq_ff;
   logic       asq_in;
   logic [0:0] reg_index;
   logic       addr_hit;

   // Registers sit on 4-byte boundaries.
   assign reg_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign addr_hit  = (reg_index == REG_ACCEPT_SQ) && (paddr[1:0] == 2'b00);

   always_comb begin
      asq_in = asq_ff;
      if (psel && penable && pwrite && addr_hit) begin
         asq_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asq_ff <= 1'b0;
      end else begin
         asq_ff <= asq_in;
      end
   end

   assign prdata = addr_hit ? {{(CSR_DATA_WIDTH-1){1'b0}}, asq_ff} : '0;
   assign pready = 1'b1;
   assign accept_single_quote = asq_ff;

endmodule

// ----- rtl/xmltok_core.sv -----
`timescale 1ns / 1ps

module xmltok_core
   import xmltok_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = 16
) (
   input  logic [7:0]              data_byte,
   input  logic                    accept_single_quote,
   input  xmltok_flags_type        flags,
   input  logic [7:0]              previous_byte,
   input  logic [LENGTH_WIDTH-1:0] token_count,
   output xmltok_flags_type        flags_next,
   output logic [LENGTH_WIDTH-1:0] token_count_next,
   output xmltok_event_type        event_res,
   output xmltok_error_type        error,
   output logic [LENGTH_WIDTH-1:0] token_length,
   output logic                    closing_tag,
   output logic [7:0]              stored_byte
);

   logic [LENGTH_WIDTH-1:0] base;
   logic                    is_quote;

   // A closed token restarts from zero with this byte.
   assign base = flags.token_open ? token_count : '0;
   assign token_count_next = (base == '1) ? base : base + 1'b1;
   assign token_length = base;

   assign is_quote = (data_byte == CHAR_DQUOTE) ||
                     ((data_byte == CHAR_SQUOTE) && accept_single_quote);

   always_comb begin
      flags_next            = flags;
      flags_next.token_open = 1'b1;
      event_res             = EV_NONE;
      error                 = ERR_NONE;
      closing_tag           = 1'b0;
      stored_byte           = data_byte;

      if (data_byte == CHAR_LT) begin
         if (!flags.in_quoted_value) begin
            if (flags.in_tag) begin
               error = ERR_OPEN_IN_TAG;
            end
            flags_next.in_tag       = 1'b1;
            flags_next.in_tag_name  = 1'b1;
            flags_next.end_tag_seen = 1'b0;
            flags_next.token_open   = 1'b0;
            event_res               = EV_TAG_OPEN;
         end
      end else if (data_byte == CHAR_GT) begin
         if (!flags.in_quoted_value) begin
            if (!flags.in_tag) begin
               error = ERR_CLOSE_OUT_TAG;
            end else begin
               flags_next.in_tag            = 1'b0;
               flags_next.in_tag_name       = 1'b0;
               flags_next.in_attribute_name = 1'b0;
               flags_next.end_tag_seen      = 1'b0;
               flags_next.token_open        = 1'b0;
               stored_byte                  = CHAR_NUL;
               event_res                    = EV_TAG_CLOSE;
               closing_tag                  = flags.end_tag_seen;
            end
         end
      end else if (is_quote) begin
         if (flags.in_quoted_value) begin
            flags_next.in_quoted_value   = 1'b0;
            flags_next.in_attribute_name = 1'b1;
            stored_byte                  = CHAR_NUL;
            event_res                    = EV_VALUE_END;
         end else begin
            flags_next.in_tag_name       = 1'b0;
            flags_next.in_attribute_name = 1'b0;
            flags_next.in_quoted_value   = 1'b1;
         end
         flags_next.token_open = 1'b0;
      end else if (data_byte == CHAR_SLASH) begin
         if (!flags.in_quoted_value && flags.in_tag && (previous_byte == CHAR_LT)) begin
            flags_next.end_tag_seen = 1'b1;
            flags_next.token_open   = 1'b0;
         end
      end else if (data_byte == CHAR_NEWLINE) begin
         stored_byte = CHAR_SPACE;
      end else if ((data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB)) begin
         if (!flags.in_quoted_value) begin
            if (flags.in_tag_name) begin
               stored_byte                  = CHAR_NUL;
               event_res                    = EV_NAME_END;
               flags_next.in_tag_name       = 1'b0;
               flags_next.in_attribute_name = 1'b1;
            end
            flags_next.token_open = 1'b0;
         end
      end else if (data_byte == CHAR_EQUALS) begin
         if (!flags.in_quoted_value) begin
            flags_next.in_attribute_name = 1'b0;
            flags_next.token_open        = 1'b0;
            stored_byte                  = CHAR_NUL;
            event_res                    = EV_ATTR_NAME_END;
         end
      end
   end

endmodule

// ----- rtl/xml_markup_byte_tokenizer.sv -----
`timescale 1ns / 1ps

// XML markup byte tokenizer.
// The req_chan channel brings one byte of XML text per request; the rsp_chan channel
// returns exactly one result per byte, in order: an event code, an error code, the
// length of the token the byte ends, the closing-tag flag and the byte as written back
// (newline as space, terminating delimiters as zero).
// The csr_ port is an APB-style register port. Register 0 (byte address 0), bit 0,
// lets an apostrophe delimit attribute values; write it only while the block is idle.
// A request taken into the input register is parsed against the flag registers into the
// result register, from which the receiver can take it.
// Throughput is one request per cycle while the receiver does not stall. The flags and
// the token counter update in the same cycle a byte moves into the result register,
// so the next byte sees them at once.
// When the receiver stalls, the result register holds, the input register keeps one
// more byte, and req_chan.ready drops only when both are full.
// Reset is synchronous: it empties both registers, clears every flag, the previous
// byte and the token counter, and turns apostrophe quoting off.

module xml_markup_byte_tokenizer
   import xmltok_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   xmltok_req_if.sink                req_chan,
   xmltok_rsp_if.source              rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic accept_single_quote;

   // Input register stage.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Parser state, kept across bytes.
   xmltok_flags_type        flags_ff;
   xmltok_flags_type        flags_in;
   logic [7:0]              prev_byte_ff;
   logic [LENGTH_WIDTH-1:0] count_ff;
   logic [LENGTH_WIDTH-1:0] count_in;

   // Result register stage.
   logic                    out_valid_ff;
   xmltok_event_type        event_ff;
   xmltok_event_type        event_in;
   xmltok_error_type        error_ff;
   xmltok_error_type        error_in;
   logic [LENGTH_WIDTH-1:0] length_ff;
   logic [LENGTH_WIDTH-1:0] length_in;
   logic                    closing_ff;
   logic                    closing_in;
   logic [7:0]              stored_ff;
   logic [7:0]              stored_in;

   logic out_ready;
   logic in_ready;
   logic advance;

   xmltok_csr u_csr (
      .clock               (clock),
      .reset               (reset),
      .psel                (csr_psel),
      .penable             (csr_penable),
      .pwrite              (csr_pwrite),
      .paddr               (csr_paddr),
      .pwdata              (csr_pwdata),
      .prdata              (csr_prdata),
      .pready              (csr_pready),
      .accept_single_quote (accept_single_quote)
   );

   // The result register can load when it is empty or its content leaves this cycle;
   // the input register can load when it is empty or its byte moves on.
   assign out_ready     = !out_valid_ff || rsp_chan.ready;
   assign advance       = in_valid_ff && out_ready;
   assign in_ready      = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   xmltok_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .data_byte           (in_byte_ff),
      .accept_single_quote (accept_single_quote),
      .flags               (flags_ff),
      .previous_byte       (prev_byte_ff),
      .token_count         (count_ff),
      .flags_next          (flags_in),
      .token_count_next    (count_in),
      .event_res           (event_in),
      .error               (error_in),
      .token_length        (length_in),
      .closing_tag         (closing_in),
      .stored_byte         (stored_in)
   );

   // State moves only when a byte is parsed into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         prev_byte_ff <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         flags_ff     <= flags_in;
         prev_byte_ff <= in_byte_ff;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff   <= event_in;
         error_ff   <= error_in;
         length_ff  <= length_in;
         closing_ff <= closing_in;
         stored_ff  <= stored_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.event_res    = event_ff;
   assign rsp_chan.error        = error_ff;
   assign rsp_chan.token_length = length_ff;
   assign rsp_chan.closing_tag  = closing_ff;
   assign rsp_chan.stored_byte  = stored_ff;

endmodule

// ----- rtl/xmltok_checker.sv -----
`timescale 1ns / 1ps

module xmltok_checker
   import xmltok_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input xmltok_event_type        rsp_event_res,
   input xmltok_error_type        rsp_error,
   input logic [LENGTH_WIDTH-1:0] rsp_token_length,
   input logic                    rsp_closing_tag,
   input logic [7:0]              rsp_stored_byte
);

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) &&
         $stable(rsp_error) && $stable(rsp_token_length) &&
         $stable(rsp_closing_tag) && $stable(rsp_stored_byte))
      else $error("stalled result changed");

   // The closing-tag flag only rides on a tag close event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closing_tag |-> rsp_event_res == EV_TAG_CLOSE)
      else $error("closing tag flag without tag close");

   // A stray close bracket gives no event; a nested open bracket still opens a tag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |->
         (rsp_error == ERR_CLOSE_OUT_TAG && rsp_event_res == EV_NONE) ||
         (rsp_error == ERR_OPEN_IN_TAG && rsp_event_res == EV_TAG_OPEN))
      else $error("error code does not match event");

   // Newlines are never written back as such.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stored_byte != CHAR_NEWLINE)
      else $error("newline passed through");

endmodule

bind xml_markup_byte_tokenizer xmltok_checker #(
   .LENGTH_WIDTH (LENGTH_WIDTH)
) u_xmltok_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_event_res    (rsp_chan.event_res),
   .rsp_error        (rsp_chan.error),
   .rsp_token_length (rsp_chan.token_length),
   .rsp_closing_tag  (rsp_chan.closing_tag),
   .rsp_stored_byte  (rsp_chan.stored_byte)
);
